// File: rtl/swaf_pkg.sv
package swaf_pkg;

	localparam int MAX_WINDOW    = 64;
	localparam int ALPHABET_SIZE = 26;

	localparam int LETTER_W = 5;
	localparam int CNT_W    = $clog2(MAX_WINDOW + 1);
	localparam int PTR_W    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int POS_W    = 32;

	typedef enum logic [1:0] {
		FUNC_PATTERN = 2'd0,
		FUNC_TEXT    = 2'd1,
		FUNC_RESTART = 2'd2,
		FUNC_CLEAR   = 2'd3
	} func_t;

	// Per-transaction commands to the histogram unit.
	typedef struct packed {
		logic                pat_inc;
		logic                pat_clear;
		logic                win_inc;
		logic                win_dec;
		logic                win_clear;
		logic [LETTER_W-1:0] letter;
		logic [LETTER_W-1:0] gone;
	} hist_ctrl_t;

endpackage

// File: rtl/sliding_window_anagram_finder_top.sv
// Sliding-window anagram search. Each input transaction carries func and letter:
// func 0 adds a pattern letter (beyond 64 pattern letters they are ignored),
// func 1 feeds a text letter, func 2 restarts the text and keeps the pattern,
// and func 3 clears everything. A func 0 or func 1 transaction with a letter
// of 26 or more is dropped without effect. Once the window of text holds as
// many letters as the pattern, each text letter is compared, and when the
// window's letter counts equal the pattern's the block emits start_index, the
// text position where the window begins. One transaction is taken every clock
// cycle; the histogram update and the 26-way compare complete in the cycle of
// acceptance, and the result is in the output queue after that edge. The
// output queue holds two results, so input is accepted while a result waits
// and stalls only when both entries are occupied. No clearing pass follows
// reset: the block is ready at once.
module sliding_window_anagram_finder_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   func,
	input  logic [swaf_pkg::LETTER_W-1:0] letter,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [swaf_pkg::POS_W-1:0]   start_index
);

	localparam logic [swaf_pkg::POS_W-1:0] POS_MAX = '1;

	// Control state.
	logic [swaf_pkg::CNT_W-1:0] plen_q;
	logic [swaf_pkg::CNT_W-1:0] fill_q;
	logic [swaf_pkg::PTR_W-1:0] wr_ptr_q;
	logic [swaf_pkg::POS_W-1:0] pos_q;

	// Letter history ring and its registered read port.
	logic [swaf_pkg::LETTER_W-1:0] hist_mem [swaf_pkg::MAX_WINDOW];
	logic [swaf_pkg::LETTER_W-1:0] rd_q;

	logic                          acc;
	logic                          letter_ok;
	logic                          is_text;
	logic                          store;
	logic                          full_win;
	logic                          match;
	logic                          push;
	logic                          fifo_full;
	logic [swaf_pkg::CNT_W-1:0]    fill_inc;
	logic [swaf_pkg::POS_W-1:0]    pos_inc;
	logic [swaf_pkg::POS_W-1:0]    result;
	logic [swaf_pkg::LETTER_W-1:0] gone;
	logic [swaf_pkg::CNT_W-1:0]    plen_d;
	logic [swaf_pkg::CNT_W-1:0]    fill_d;
	logic [swaf_pkg::PTR_W-1:0]    wr_ptr_d;
	logic [swaf_pkg::POS_W-1:0]    pos_d;
	logic [swaf_pkg::CNT_W-1:0]    wr_ext;
	logic [swaf_pkg::PTR_W-1:0]    rd_addr_d;
	swaf_pkg::func_t               fn;
	swaf_pkg::hist_ctrl_t          hctrl;

	assign fn        = swaf_pkg::func_t'(func);
	assign in_ready  = !fifo_full;
	assign acc       = in_valid && in_ready;
	assign letter_ok = (letter < swaf_pkg::LETTER_W'(swaf_pkg::ALPHABET_SIZE));
	assign is_text   = acc && (fn == swaf_pkg::FUNC_TEXT) && letter_ok;

	// With an empty pattern a text letter only advances the position.
	assign store    = is_text && (plen_q != '0);
	assign fill_inc = fill_q + swaf_pkg::CNT_W'(1);
	// The window never holds more than the pattern length, so reaching it
	// means the window is full with this letter.
	assign full_win = store && (fill_inc >= plen_q);
	assign push     = full_win && match;

	assign pos_inc = (pos_q == POS_MAX) ? pos_q : pos_q + swaf_pkg::POS_W'(1);
	assign result  = pos_inc - swaf_pkg::POS_W'(fill_inc);

	// The oldest letter sits at wr_ptr - fill before this letter is written.
	// An empty window means the new letter itself is the oldest one.
	assign gone = (fill_q == '0) ? letter : rd_q;

	always_comb begin
		hctrl           = '0;
		hctrl.letter    = letter;
		hctrl.gone      = gone;
		hctrl.pat_inc   = acc && (fn == swaf_pkg::FUNC_PATTERN) && letter_ok &&
			(plen_q < swaf_pkg::CNT_W'(swaf_pkg::MAX_WINDOW));
		hctrl.pat_clear = acc && (fn == swaf_pkg::FUNC_CLEAR);
		hctrl.win_inc   = store;
		hctrl.win_dec   = full_win;
		hctrl.win_clear = acc && ((fn == swaf_pkg::FUNC_RESTART) ||
			(fn == swaf_pkg::FUNC_CLEAR));
	end

	// Next state of the counters and pointers.
	always_comb begin
		plen_d   = plen_q;
		fill_d   = fill_q;
		wr_ptr_d = wr_ptr_q;
		pos_d    = pos_q;
		if (acc) begin
			unique case (fn)
				swaf_pkg::FUNC_PATTERN: begin
					if (hctrl.pat_inc) begin
						plen_d = plen_q + swaf_pkg::CNT_W'(1);
					end
				end
				swaf_pkg::FUNC_TEXT: begin
					if (is_text) begin
						pos_d = pos_inc;
					end
					if (store) begin
						fill_d   = full_win ? fill_q : fill_inc;
						wr_ptr_d = (wr_ptr_q == swaf_pkg::PTR_W'(swaf_pkg::MAX_WINDOW - 1)) ?
							'0 : wr_ptr_q + swaf_pkg::PTR_W'(1);
					end
				end
				swaf_pkg::FUNC_RESTART: begin
					fill_d   = '0;
					wr_ptr_d = '0;
					pos_d    = '0;
				end
				swaf_pkg::FUNC_CLEAR: begin
					plen_d   = '0;
					fill_d   = '0;
					wr_ptr_d = '0;
					pos_d    = '0;
				end
				default: begin
					plen_d = plen_q;
				end
			endcase
		end
	end

	// Address of the oldest letter for the next transaction, modulo the ring.
	always_comb begin
		wr_ext = swaf_pkg::CNT_W'(wr_ptr_d);
		if (wr_ext >= fill_d) begin
			rd_addr_d = swaf_pkg::PTR_W'(wr_ext - fill_d);
		end else begin
			rd_addr_d = swaf_pkg::PTR_W'(wr_ext + swaf_pkg::CNT_W'(swaf_pkg::MAX_WINDOW) -
				fill_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q   <= '0;
			fill_q   <= '0;
			wr_ptr_q <= '0;
			pos_q    <= '0;
		end else begin
			plen_q   <= plen_d;
			fill_q   <= fill_d;
			wr_ptr_q <= wr_ptr_d;
			pos_q    <= pos_d;
		end
	end

	// The read of the oldest letter is prefetched into a register for the next
	// transaction; a letter written to the same entry in this cycle is forwarded.
	always_ff @(posedge clk) begin
		if (store) begin
			hist_mem[wr_ptr_q] <= letter;
		end
		if (store && (wr_ptr_q == rd_addr_d)) begin
			rd_q <= letter;
		end else begin
			rd_q <= hist_mem[rd_addr_d];
		end
	end

	swaf_hist u_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (hctrl),
		.match  (match)
	);

	swaf_res_fifo u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.din       (result),
		.full      (fifo_full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.dout      (start_index)
	);

	// The window stays empty while the pattern is empty.
	a_empty_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		(plen_q == '0) |-> (fill_q == '0))
		else $error("window holds letters with an empty pattern");

	// Between transactions the window is always shorter than the pattern.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(plen_q != '0) |-> (fill_q < plen_q))
		else $error("window fill reached the pattern length");

	// A new result can only follow an accepted text letter.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(is_text))
		else $error("result appeared without a text transaction");

endmodule

// File: rtl/swaf_hist.sv
module swaf_hist (
	input  logic                clk,
	input  logic                arst_n,
	input  swaf_pkg::hist_ctrl_t ctrl,
	output logic                match
);

	logic [swaf_pkg::CNT_W-1:0] pat_q   [swaf_pkg::ALPHABET_SIZE];
	logic [swaf_pkg::CNT_W-1:0] win_q   [swaf_pkg::ALPHABET_SIZE];
	logic [swaf_pkg::CNT_W-1:0] win_mid [swaf_pkg::ALPHABET_SIZE];
	logic [swaf_pkg::ALPHABET_SIZE-1:0] equal;

	// The window count including the incoming letter is what gets compared.
	always_comb begin
		for (int i = 0; i < swaf_pkg::ALPHABET_SIZE; i++) begin
			win_mid[i] = win_q[i] + swaf_pkg::CNT_W'(ctrl.win_inc &&
				(ctrl.letter == swaf_pkg::LETTER_W'(i)));
			equal[i] = (win_mid[i] == pat_q[i]);
		end
	end

	assign match = &equal;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < swaf_pkg::ALPHABET_SIZE; i++) begin
				pat_q[i] <= '0;
				win_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < swaf_pkg::ALPHABET_SIZE; i++) begin
				priority if (ctrl.pat_clear) begin
					pat_q[i] <= '0;
				end else if (ctrl.pat_inc && (ctrl.letter == swaf_pkg::LETTER_W'(i))) begin
					pat_q[i] <= pat_q[i] + swaf_pkg::CNT_W'(1);
				end else begin
					pat_q[i] <= pat_q[i];
				end

				priority if (ctrl.win_clear) begin
					win_q[i] <= '0;
				end else if (ctrl.win_dec && (ctrl.gone == swaf_pkg::LETTER_W'(i)) &&
						(win_mid[i] != '0)) begin
					win_q[i] <= win_mid[i] - swaf_pkg::CNT_W'(1);
				end else begin
					win_q[i] <= win_mid[i];
				end
			end
		end
	end

endmodule

// File: rtl/swaf_res_fifo.sv
module swaf_res_fifo (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  logic [swaf_pkg::POS_W-1:0] din,
	output logic                     full,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [swaf_pkg::POS_W-1:0] dout
);

	logic [1:0]                 cnt_q;
	logic [swaf_pkg::POS_W-1:0] head_q;
	logic [swaf_pkg::POS_W-1:0] tail_q;
	logic                       pop;

	assign out_valid = (cnt_q != 2'd0);
	assign full      = (cnt_q == 2'd2);
	assign dout      = head_q;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && pop) begin
			if (cnt_q == 2'd1) begin
				head_q <= din;
			end else begin
				head_q <= tail_q;
				tail_q <= din;
			end
		end else if (pop) begin
			head_q <= tail_q;
		end else if (push) begin
			if (cnt_q == 2'd0) begin
				head_q <= din;
			end else begin
				tail_q <= din;
			end
		end
	end

endmodule

// File: tb/sv/tb_sliding_window_anagram_finder_top.sv
`timescale 1ns / 1ps

module tb_sliding_window_anagram_finder_top;

	// A result is registered into the output queue as the input transaction
	// that causes it is accepted; the drain wait at the end adds a margin.
	localparam int DRAIN_CYCLES = 10;
	// The slowest correct run is under 1000 transactions, each waiting out the
	// longest sender gap and the longest receiver stall, plus the long hold-off,
	// so this limit leaves a wide margin.
	localparam int CYCLE_LIMIT = 250000;
	localparam int RANDOM_ITEMS = 900;
	localparam int HOLD_CYCLES = 300;

	// Mirror of the block's letter counts. It keeps its own pattern and window
	// histograms, ring of window letters and text position, and it queues
	// the start index that each matching text letter is expected to report.
	class anagram_tracker;
		bit [swaf_pkg::CNT_W-1:0]    pat_count[swaf_pkg::ALPHABET_SIZE];
		bit [swaf_pkg::CNT_W-1:0]    win_count[swaf_pkg::ALPHABET_SIZE];
		bit [swaf_pkg::CNT_W-1:0]    pat_len;
		bit [swaf_pkg::CNT_W-1:0]    fill;
		bit [swaf_pkg::LETTER_W-1:0] ring[swaf_pkg::MAX_WINDOW];
		bit [swaf_pkg::POS_W-1:0]    pos;
		int                          wr_ptr;
		bit [swaf_pkg::POS_W-1:0]    expected_starts[$];
		int                          errors;

		function new();
			errors = 0;
			clear_all();
		endfunction

		function void restart_text();
			foreach (win_count[i])
				win_count[i] = '0;
			fill = '0;
			pos = '0;
			wr_ptr = 0;
		endfunction

		function void clear_all();
			foreach (pat_count[i])
				pat_count[i] = '0;
			foreach (ring[i])
				ring[i] = '0;
			pat_len = '0;
			restart_text();
		endfunction

		function void take_transaction(swaf_pkg::func_t f, bit [swaf_pkg::LETTER_W-1:0] l);
			bit                          same;
			int                          oldest;
			bit [swaf_pkg::LETTER_W-1:0] gone;
			bit [swaf_pkg::POS_W-1:0]    start_pos;
			case (f)
				swaf_pkg::FUNC_PATTERN: begin
					if (l < swaf_pkg::ALPHABET_SIZE && pat_len < swaf_pkg::MAX_WINDOW) begin
						pat_count[l]++;
						pat_len++;
					end
				end
				swaf_pkg::FUNC_TEXT: begin
					if (l < swaf_pkg::ALPHABET_SIZE) begin
						if (pos != '1)
							pos++;
						if (pat_len != 0) begin
							win_count[l]++;
							ring[wr_ptr] = l;
							wr_ptr = (wr_ptr + 1) % swaf_pkg::MAX_WINDOW;
							fill++;
							if (fill >= pat_len) begin
								same = 1'b1;
								foreach (win_count[i])
									if (win_count[i] != pat_count[i])
										same = 1'b0;
								if (same) begin
									start_pos = pos - fill;
									expected_starts = {expected_starts, start_pos};
								end
								oldest = (wr_ptr + swaf_pkg::MAX_WINDOW -
									(int'(fill) % swaf_pkg::MAX_WINDOW)) % swaf_pkg::MAX_WINDOW;
								gone = ring[oldest];
								if (gone < swaf_pkg::ALPHABET_SIZE && win_count[gone] > 0)
									win_count[gone]--;
								fill--;
							end
						end
					end
				end
				swaf_pkg::FUNC_RESTART: restart_text();
				default: clear_all();
			endcase
		endfunction

		function void check_start(bit [swaf_pkg::POS_W-1:0] actual);
			bit [swaf_pkg::POS_W-1:0] want;
			if (expected_starts.size() == 0) begin
				$error("start_index: expected no result, actual %0d", actual);
				errors++;
			end else begin
				want = expected_starts.pop_front();
				if (want != actual) begin
					$error("start_index: expected %0d, actual %0d", want, actual);
					errors++;
				end
			end
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	logic [1:0]                    func;
	logic [swaf_pkg::LETTER_W-1:0] letter;
	logic                          out_valid;
	logic                          out_ready;
	logic [swaf_pkg::POS_W-1:0]    start_index;

	anagram_tracker tracker;

	int items_sent;
	int cycle_count;
	bit tx_fast;
	bit rx_fast;
	bit rx_hold;
	bit hold_request;
	int rx_wait;

	sliding_window_anagram_finder_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.letter      (letter),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.start_index (start_index)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Watchdog: a run that hangs on a handshake ends here as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// The receiver decides out_ready at each falling edge. A hold-off from the
	// pressure process overrides everything; otherwise the countdown drawn
	// after the previous transaction keeps ready low until it runs out.
	// Now and then it switches between random stalls and no stalls at all.
	always @(negedge clk) begin
		if ($urandom_range(0, 99) == 0)
			rx_fast = ~rx_fast;
		if (rx_hold) begin
			out_ready = 1'b0;
		end else if (rx_wait > 0) begin
			out_ready = 1'b0;
			rx_wait--;
		end else begin
			out_ready = 1'b1;
		end
	end

	// Results are checked at the rising edge where the output transaction
	// completes, and a fresh stall is drawn for the next one.
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			tracker.check_start(start_index);
			rx_wait = rx_fast ? 0 : $urandom_range(0, 14);
		end
	end

	// Long receiver hold-off, counted in its own process. The sender keeps
	// streaming matching text meanwhile, so the two-entry output queue fills
	// and in_ready must drop until the receiver comes back.
	initial begin
		rx_hold = 1'b0;
		wait (hold_request);
		@(posedge clk);
		rx_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold = 1'b0;
	end

	function automatic int draw_gap();
		return tx_fast ? 0 : $urandom_range(0, 14);
	endfunction

	// Offers one input transaction after the given number of idle cycles and
	// returns at the rising edge where it is accepted. Valid stays high with a
	// steady payload until then, and it is never lowered between items that
	// follow each other without a gap.
	task automatic send(swaf_pkg::func_t f, bit [swaf_pkg::LETTER_W-1:0] l, int gap);
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid = 1'b1;
		func = f;
		letter = l;
		do @(posedge clk); while (!in_ready);
		tracker.take_transaction(f, l);
		items_sent++;
	endtask

	task automatic directed_items();
		tx_fast = 1'b0;
		// With no pattern, a text letter only moves the position forward.
		send(swaf_pkg::FUNC_TEXT, 5'd0, draw_gap());
		// Pattern "az"; the two letters 31 and 26 are out of range and dropped.
		send(swaf_pkg::FUNC_PATTERN, 5'd0, draw_gap());
		send(swaf_pkg::FUNC_PATTERN, 5'd25, draw_gap());
		send(swaf_pkg::FUNC_PATTERN, 5'd31, draw_gap());
		send(swaf_pkg::FUNC_PATTERN, 5'd26, draw_gap());
		// Text "za" matches at position 1, then "az" at 2 and "za" at 3.
		send(swaf_pkg::FUNC_TEXT, 5'd25, draw_gap());
		send(swaf_pkg::FUNC_TEXT, 5'd0, draw_gap());
		send(swaf_pkg::FUNC_TEXT, 5'd31, draw_gap());
		send(swaf_pkg::FUNC_TEXT, 5'd25, draw_gap());
		send(swaf_pkg::FUNC_TEXT, 5'd0, draw_gap());
		// Restart keeps the pattern, and the position counts from zero again.
		send(swaf_pkg::FUNC_RESTART, 5'd31, draw_gap());
		send(swaf_pkg::FUNC_TEXT, 5'd0, draw_gap());
		send(swaf_pkg::FUNC_TEXT, 5'd25, draw_gap());
		// The pattern grows in the middle of the text; the window keeps
		// filling until it holds three letters.
		send(swaf_pkg::FUNC_PATTERN, 5'd0, draw_gap());
		send(swaf_pkg::FUNC_TEXT, 5'd0, draw_gap());
		send(swaf_pkg::FUNC_TEXT, 5'd1, draw_gap());
		// Clear everything, then a text letter against the empty pattern,
		// and afterwards a one-letter pattern that matches at once.
		send(swaf_pkg::FUNC_CLEAR, 5'd17, draw_gap());
		send(swaf_pkg::FUNC_TEXT, 5'd3, draw_gap());
		send(swaf_pkg::FUNC_PATTERN, 5'd3, draw_gap());
		send(swaf_pkg::FUNC_TEXT, 5'd3, draw_gap());
		send(swaf_pkg::FUNC_TEXT, 5'd30, draw_gap());
		send(swaf_pkg::FUNC_TEXT, 5'd3, draw_gap());
	endtask

	// One-letter pattern and a burst of the same letter: every text letter
	// matches, and the receiver is held off as the burst starts.
	task automatic pressure_burst();
		bit [swaf_pkg::LETTER_W-1:0] l;
		l = swaf_pkg::LETTER_W'($urandom_range(0, swaf_pkg::ALPHABET_SIZE - 1));
		tx_fast = 1'b1;
		send(swaf_pkg::FUNC_CLEAR, swaf_pkg::LETTER_W'($urandom_range(0, 31)), 0);
		send(swaf_pkg::FUNC_PATTERN, l, 0);
		hold_request = 1'b1;
		repeat (40) send(swaf_pkg::FUNC_TEXT, l, 0);
	endtask

	// More pattern letters than the window can hold, so the pattern saturates
	// and the window runs completely full.
	task automatic full_window_run();
		bit [swaf_pkg::LETTER_W-1:0] l;
		bit [swaf_pkg::LETTER_W-1:0] other;
		l = swaf_pkg::LETTER_W'($urandom_range(0, swaf_pkg::ALPHABET_SIZE - 1));
		other = swaf_pkg::LETTER_W'((l + 1) % swaf_pkg::ALPHABET_SIZE);
		tx_fast = ($urandom_range(0, 1) == 0);
		send(swaf_pkg::FUNC_CLEAR, swaf_pkg::LETTER_W'($urandom_range(0, 31)), draw_gap());
		repeat ($urandom_range(swaf_pkg::MAX_WINDOW + 2, swaf_pkg::MAX_WINDOW + 8))
			send(swaf_pkg::FUNC_PATTERN, l, draw_gap());
		repeat (90)
			send(swaf_pkg::FUNC_TEXT, ($urandom_range(0, 9) == 0) ? other : l, draw_gap());
	endtask

	// A well-formed search over a small alphabet so that matches are common,
	// with occasional out-of-range letters, pattern growth and restarts.
	task automatic search_sequence();
		int base;
		int span;
		int r;
		base = $urandom_range(0, swaf_pkg::ALPHABET_SIZE - 1);
		span = $urandom_range(1, 3);
		tx_fast = ($urandom_range(0, 3) == 0);
		if ($urandom_range(0, 4) == 0)
			send(swaf_pkg::FUNC_RESTART, swaf_pkg::LETTER_W'($urandom_range(0, 31)),
				draw_gap());
		else
			send(swaf_pkg::FUNC_CLEAR, swaf_pkg::LETTER_W'($urandom_range(0, 31)),
				draw_gap());
		repeat ($urandom_range(0, 5))
			send(swaf_pkg::FUNC_PATTERN, swaf_pkg::LETTER_W'((base +
				$urandom_range(0, span - 1)) % swaf_pkg::ALPHABET_SIZE), draw_gap());
		repeat ($urandom_range(6, 30)) begin
			r = $urandom_range(0, 39);
			if (r == 0)
				send(swaf_pkg::FUNC_RESTART, swaf_pkg::LETTER_W'($urandom_range(0, 31)),
					draw_gap());
			else if (r <= 2)
				send(swaf_pkg::FUNC_PATTERN, swaf_pkg::LETTER_W'((base +
					$urandom_range(0, span - 1)) % swaf_pkg::ALPHABET_SIZE), draw_gap());
			else if (r <= 4)
				send(swaf_pkg::func_t'($urandom_range(0, 1)),
					swaf_pkg::LETTER_W'($urandom_range(swaf_pkg::ALPHABET_SIZE, 31)),
					draw_gap());
			else
				send(swaf_pkg::FUNC_TEXT, swaf_pkg::LETTER_W'((base +
					$urandom_range(0, span - 1)) % swaf_pkg::ALPHABET_SIZE), draw_gap());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = swaf_pkg::FUNC_PATTERN;
		letter = '0;
		out_ready = 1'b0;
		hold_request = 1'b0;
		rx_fast = 1'b0;
		rx_wait = 0;
		items_sent = 0;
		cycle_count = 0;
		tracker = new();
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		directed_items();
		items_sent = 0;
		pressure_burst();
		full_window_run();
		while (items_sent < RANDOM_ITEMS)
			search_sequence();

		@(negedge clk);
		in_valid = 1'b0;
		while (tracker.expected_starts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (tracker.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
